FILE: rtl/core/point_cloud_normal_shading_macros.svh
// Assertion macros shared by the shading block's checkers.
`ifndef POINT_CLOUD_NORMAL_SHADING_MACROS_SVH
`define POINT_CLOUD_NORMAL_SHADING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pcns_pkg.sv
// Types and constants of the point cloud shading block.
package pcns_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MIN_DIM      = 3;
    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int Q_ONE        = 16384;
    localparam int Q_SHIFT      = 14;
    localparam int SHADE_BITS   = 16;
    localparam int NORM_BITS    = 30;
    localparam int ROOT_BITS    = 32;
    localparam int QUOT_BITS    = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(480);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic                         frame_start;
    } t_in_word;

    typedef struct packed {
        logic signed [SHADE_BITS-1:0] shade;
        logic                         frame_end;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

endpackage

FILE: rtl/core/pcns_ram.sv
// Generic single-port-write, registered-read RAM.
module pcns_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/point_cloud_normal_shading.sv
// Point cloud surface normal estimation with Lambert shading, top level.
// A pixel's shade word is computed once the word carrying its lower-right neighbor is accepted;
// it then passes stages 1-10, the root seed, the root and divide stages and the output register.
// Throughput: one point word per cycle; the whole pipe holds only on output stall.
// Reset (sync, active low): counters to zero, registers to 640 x 480, pipe emptied.
module point_cloud_normal_shading
    import pcns_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_in_word                i_word,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_out_word               o_word
);

    // ------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------
    localparam int CW   = $clog2(MAX_WIDTH);          // column index
    localparam int RW   = $clog2(MAX_HEIGHT);         // row index
    localparam int PW   = ((CW > RW) ? CW : RW) + 1;  // position math, holds size itself
    localparam int PTW  = $bits(t_point);
    localparam int DW   = COORD_BITS + 1;             // diagonal differences
    localparam int PRW  = 2 * DW;                     // partial products
    localparam int NW   = PRW + 1;                    // normal components
    localparam int PBW  = $clog2(NW);                 // msb index
    localparam int SW   = NW + NORM_BITS - 1;         // normalize shifter
    localparam int SGW  = NORM_BITS + 1;              // signed normalized
    localparam int SUMW = NORM_BITS + 2;              // nx + ny
    localparam int SQW  = 2 * NORM_BITS;              // squares
    localparam int RADW = 2 * ROOT_BITS;              // radicand
    localparam int RMW  = ROOT_BITS + 3;              // root remainder
    localparam int NUMW = SUMW + Q_SHIFT + 1;         // divide numerator

    typedef struct packed {
        logic zero;   // force shade to 0 (no depth or null normal)
        logic neg;    // nx + ny negative
        logic fe;     // last interior pixel of frame
    } t_tag;

    // ------------------------------------------------------------------
    // Flow control: every stage moves together, held only while the
    // output word is valid and stalled.
    // ------------------------------------------------------------------
    logic en, acc;
    logic r_ovld;
    t_out_word r_out;

    assign en      = !r_ovld || !i_stall;
    assign acc     = i_valid && en;
    assign o_stall = !en;
    assign o_valid = r_ovld;
    assign o_word  = r_out;

    // ------------------------------------------------------------------
    // Configuration and raster position
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0] r_frame_width, r_frame_height;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [PW-1:0] fw, fh, w_eff, h_eff, c_a, r_a, c_b, r_b, c_n, r_n;
    logic          emit, fe_pos;

    always_comb begin
        fw = PW'(r_frame_width);
        fh = PW'(r_frame_height);
        if (fw < PW'(MIN_DIM)) begin
            w_eff = PW'(MIN_DIM);
        end else if (fw > PW'(MAX_WIDTH)) begin
            w_eff = PW'(MAX_WIDTH);
        end else begin
            w_eff = fw;
        end
        if (fh < PW'(MIN_DIM)) begin
            h_eff = PW'(MIN_DIM);
        end else if (fh > PW'(MAX_HEIGHT)) begin
            h_eff = PW'(MAX_HEIGHT);
        end else begin
            h_eff = fh;
        end

        // frame_start restarts the raster; stale counts (after a size change) wrap
        c_a = i_word.frame_start ? '0 : PW'(r_col);
        r_a = i_word.frame_start ? '0 : PW'(r_row);
        c_b = c_a;
        r_b = r_a;
        if (c_a >= w_eff) begin
            c_b = '0;
            r_b = r_a + PW'(1);
        end
        if (r_b >= h_eff) begin
            r_b = '0;
        end

        c_n = c_b + PW'(1);
        r_n = r_b + PW'(1);
        if (c_n >= w_eff) begin
            n_col = '0;
            n_row = (r_n >= h_eff) ? '0 : RW'(r_n);
        end else begin
            n_col = CW'(c_n);
            n_row = RW'(r_b);
        end

        emit   = (r_b >= PW'(2)) && (c_b >= PW'(2));
        fe_pos = (r_b == h_eff - PW'(1)) && (c_b == w_eff - PW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                endcase
            end
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read. Stores are read at accept and written from
    // the stage 1 registers; a back-to-back hit on the same column (frame_start
    // twice in a row) is forwarded from the stage 1 word.
    // ------------------------------------------------------------------
    t_point        p_in;
    t_point        r_p1, r_byp_up1, r_byp_mid1;
    logic [CW-1:0] r_c1;
    logic          r_v1, r_emit1, r_fe1, r_byp1;
    logic [PTW-1:0] up_rd, mid_rd;
    t_point        up_eff1, mid_eff1;

    assign p_in     = '{x: i_word.point_x, y: i_word.point_y, z: i_word.point_z};
    assign up_eff1  = r_byp1 ? r_byp_up1  : t_point'(up_rd);
    assign mid_eff1 = r_byp1 ? r_byp_mid1 : t_point'(mid_rd);

    pcns_ram #(
        .WIDTH (PTW),
        .DEPTH (MAX_WIDTH)
    ) u_row_upper (
        .i_clk   (i_clk),
        .i_we    (en && r_v1),
        .i_waddr (r_c1),
        .i_wdata (PTW'(mid_eff1)),
        .i_re    (en),
        .i_raddr (CW'(c_b)),
        .o_rdata (up_rd)
    );

    pcns_ram #(
        .WIDTH (PTW),
        .DEPTH (MAX_WIDTH)
    ) u_row_middle (
        .i_clk   (i_clk),
        .i_we    (en && r_v1),
        .i_waddr (r_c1),
        .i_wdata (PTW'(r_p1)),
        .i_re    (en),
        .i_raddr (CW'(c_b)),
        .o_rdata (mid_rd)
    );

    // ------------------------------------------------------------------
    // Stage 2: 3x3 window, shifts once per point.
    // ------------------------------------------------------------------
    t_point r_win [9];
    logic   r_v2, r_fe2;

    // Stage 3: diagonals d = lower-right - upper-left, e = lower-left - upper-right.
    // The four-cross-product sum equals e x d, the centre cancels out.
    logic signed [DW-1:0] r_dx, r_dy, r_dz, r_ex, r_ey, r_ez;
    logic                 r_v3;
    t_tag                 r_tag3;

    // Stage 4: products
    logic signed [PRW-1:0] r_eydz, r_ezdy, r_ezdx, r_exdz, r_exdy, r_eydx;
    logic                  r_v4;
    t_tag                  r_tag4;

    // Stage 5: normal n = e x d
    logic signed [NW-1:0] r_nx, r_ny, r_nz;
    logic                 r_v5;
    t_tag                 r_tag5;

    // Stage 6: magnitudes
    logic [NW-1:0] r_mx6, r_my6, r_mz6;
    logic [1:0]    r_sgn6;
    logic          r_v6;
    t_tag          r_tag6;

    // Stage 7: largest magnitude
    logic [NW-1:0] r_mx7, r_my7, r_mz7, r_m7, max_m;
    logic [1:0]    r_sgn7;
    logic          r_v7;
    t_tag          r_tag7;

    // Stage 8: leading one of the largest magnitude
    logic [NW-1:0]  r_mx8, r_my8, r_mz8;
    logic [PBW-1:0] r_msb8, msb_idx;
    logic [1:0]     r_sgn8;
    logic           r_v8;
    t_tag           r_tag8;

    // Stage 9: normalize so the largest lands in [2^29, 2^30)
    logic [NORM_BITS-1:0] r_hx9, r_hy9, r_hz9;
    logic [SW-1:0]        sh_x, sh_y, sh_z;
    logic [1:0]           r_sgn9;
    logic                 r_v9;
    t_tag                 r_tag9;

    // Stage 10: a = |nx + ny|, squares
    logic signed [SGW-1:0]  sx, sy;
    logic signed [SUMW-1:0] s_sum;
    logic [SQW-1:0]         r_qx, r_qy, r_qz;
    logic [SUMW-1:0]        r_a10;
    logic                   r_v10;
    t_tag                   r_tag10;

    // Stage 11 and root stages: digit-by-digit square root, two radicand
    // bits per stage
    logic                 r_sq_v    [ROOT_BITS+1];
    logic [RADW-1:0]      r_sq_rad  [ROOT_BITS+1];
    logic [RMW-1:0]       r_sq_rem  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] r_sq_root [ROOT_BITS+1];
    logic [SUMW-1:0]      r_sq_a    [ROOT_BITS+1];
    t_tag                 r_sq_tag  [ROOT_BITS+1];

    // Divide prep and restoring divide stages, one quotient bit per stage
    logic                 r_dv_v   [QUOT_BITS+1];
    logic [ROOT_BITS-1:0] r_dv_rem [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] r_dv_num [QUOT_BITS+1];
    logic [ROOT_BITS-1:0] r_dv_den [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] r_dv_q   [QUOT_BITS+1];
    t_tag                 r_dv_tag [QUOT_BITS+1];

    logic [NUMW-1:0]       numer;
    logic [QUOT_BITS-1:0]  q_clip;
    logic [SHADE_BITS-1:0] shade_n;

    always_comb begin
        max_m = r_mx6;
        if (r_my6 > max_m) begin
            max_m = r_my6;
        end
        if (r_mz6 > max_m) begin
            max_m = r_mz6;
        end

        msb_idx = '0;
        for (int b = 0; b < NW; b++) begin
            if (r_m7[b]) begin
                msb_idx = PBW'(b);
            end
        end

        // value * 2^29 / 2^msb: right shifts truncate, left shifts are exact
        sh_x = (SW'(r_mx8) << (NORM_BITS - 1)) >> r_msb8;
        sh_y = (SW'(r_my8) << (NORM_BITS - 1)) >> r_msb8;
        sh_z = (SW'(r_mz8) << (NORM_BITS - 1)) >> r_msb8;

        sx    = r_sgn9[0] ? -$signed(SGW'(r_hx9)) : $signed(SGW'(r_hx9));
        sy    = r_sgn9[1] ? -$signed(SGW'(r_hy9)) : $signed(SGW'(r_hy9));
        s_sum = SUMW'(sx) + SUMW'(sy);

        numer = NUMW'({r_sq_a[ROOT_BITS], {Q_SHIFT{1'b0}}})
              + NUMW'(r_sq_root[ROOT_BITS] >> 1);

        q_clip  = (r_dv_q[QUOT_BITS] > QUOT_BITS'(Q_ONE)) ? QUOT_BITS'(Q_ONE)
                                                         : r_dv_q[QUOT_BITS];
        if (r_dv_tag[QUOT_BITS].zero) begin
            shade_n = '0;
        end else if (r_dv_tag[QUOT_BITS].neg) begin
            shade_n = SHADE_BITS'(-q_clip);
        end else begin
            shade_n = SHADE_BITS'(q_clip);
        end
    end

    // Valid bits of the front stages, divide prep and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_v6      <= 1'b0;
            r_v7      <= 1'b0;
            r_v8      <= 1'b0;
            r_v9      <= 1'b0;
            r_v10     <= 1'b0;
            r_sq_v[0] <= 1'b0;
            r_dv_v[0] <= 1'b0;
            r_ovld    <= 1'b0;
        end else if (en) begin
            r_v1      <= acc;
            r_v2      <= r_v1 && r_emit1;   // border pixels stop here
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_v6      <= r_v5;
            r_v7      <= r_v6;
            r_v8      <= r_v7;
            r_v9      <= r_v8;
            r_v10     <= r_v9;
            r_sq_v[0] <= r_v10;
            r_dv_v[0] <= r_sq_v[ROOT_BITS];
            r_ovld    <= r_dv_v[QUOT_BITS];
        end
    end

    // Payload of the front stages, divide prep and output
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r_p1       <= p_in;
            r_c1       <= CW'(c_b);
            r_emit1    <= emit;
            r_fe1      <= fe_pos;
            r_byp1     <= r_v1 && (r_c1 == CW'(c_b));
            r_byp_up1  <= mid_eff1;
            r_byp_mid1 <= r_p1;

            // stage 2
            if (r_v1) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]     <= r_win[k*3 + 1];
                    r_win[k*3 + 1] <= r_win[k*3 + 2];
                end
                r_win[2] <= up_eff1;
                r_win[5] <= mid_eff1;
                r_win[8] <= r_p1;
            end
            r_fe2 <= r_fe1;

            // stage 3
            r_dx   <= DW'(r_win[8].x) - DW'(r_win[0].x);
            r_dy   <= DW'(r_win[8].y) - DW'(r_win[0].y);
            r_dz   <= DW'(r_win[8].z) - DW'(r_win[0].z);
            r_ex   <= DW'(r_win[6].x) - DW'(r_win[2].x);
            r_ey   <= DW'(r_win[6].y) - DW'(r_win[2].y);
            r_ez   <= DW'(r_win[6].z) - DW'(r_win[2].z);
            r_tag3 <= '{zero: (r_win[4].z == '0), neg: 1'b0, fe: r_fe2};

            // stage 4
            r_eydz <= PRW'(r_ey) * PRW'(r_dz);
            r_ezdy <= PRW'(r_ez) * PRW'(r_dy);
            r_ezdx <= PRW'(r_ez) * PRW'(r_dx);
            r_exdz <= PRW'(r_ex) * PRW'(r_dz);
            r_exdy <= PRW'(r_ex) * PRW'(r_dy);
            r_eydx <= PRW'(r_ey) * PRW'(r_dx);
            r_tag4 <= r_tag3;

            // stage 5
            r_nx   <= NW'(r_eydz) - NW'(r_ezdy);
            r_ny   <= NW'(r_ezdx) - NW'(r_exdz);
            r_nz   <= NW'(r_exdy) - NW'(r_eydx);
            r_tag5 <= r_tag4;

            // stage 6
            r_mx6  <= r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
            r_my6  <= r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
            r_mz6  <= r_nz[NW-1] ? NW'(-r_nz) : NW'(r_nz);
            r_sgn6 <= {r_ny[NW-1], r_nx[NW-1]};
            r_tag6 <= r_tag5;

            // stage 7
            r_mx7  <= r_mx6;
            r_my7  <= r_my6;
            r_mz7  <= r_mz6;
            r_m7   <= max_m;
            r_sgn7 <= r_sgn6;
            r_tag7 <= '{zero: r_tag6.zero || (max_m == '0), neg: 1'b0, fe: r_tag6.fe};

            // stage 8
            r_mx8  <= r_mx7;
            r_my8  <= r_my7;
            r_mz8  <= r_mz7;
            r_msb8 <= msb_idx;
            r_sgn8 <= r_sgn7;
            r_tag8 <= r_tag7;

            // stage 9
            r_hx9  <= sh_x[NORM_BITS-1:0];
            r_hy9  <= sh_y[NORM_BITS-1:0];
            r_hz9  <= sh_z[NORM_BITS-1:0];
            r_sgn9 <= r_sgn8;
            r_tag9 <= r_tag8;

            // stage 10
            r_qx    <= SQW'(r_hx9) * SQW'(r_hx9);
            r_qy    <= SQW'(r_hy9) * SQW'(r_hy9);
            r_qz    <= SQW'(r_hz9) * SQW'(r_hz9);
            r_a10   <= s_sum[SUMW-1] ? SUMW'(-s_sum) : SUMW'(s_sum);
            r_tag10 <= '{zero: r_tag9.zero, neg: s_sum[SUMW-1], fe: r_tag9.fe};

            // stage 11: D = 2 (x^2 + y^2 + z^2)
            r_sq_rad[0]  <= (RADW'(r_qx) + RADW'(r_qy) + RADW'(r_qz)) << 1;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_a[0]    <= r_a10;
            r_sq_tag[0]  <= r_tag10;

            // divide prep: numerator 16384 a + r/2, top part seeds the remainder
            r_dv_rem[0] <= ROOT_BITS'(numer >> QUOT_BITS);
            r_dv_num[0] <= numer[QUOT_BITS-1:0];
            r_dv_den[0] <= r_sq_root[ROOT_BITS];
            r_dv_q[0]   <= '0;
            r_dv_tag[0] <= r_sq_tag[ROOT_BITS];

            // output register
            r_out <= '{shade: shade_n, frame_end: r_dv_tag[QUOT_BITS].fe};
        end
    end

    // Square root stages
    for (genvar gk = 0; gk < ROOT_BITS; gk++) begin : g_sqrt
        logic [RMW-1:0] rem_sh, trial;
        logic           ge;

        assign rem_sh = {r_sq_rem[gk][RMW-3:0], r_sq_rad[gk][RADW-1 -: 2]};
        assign trial  = RMW'({r_sq_root[gk], 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[gk+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[gk+1]    <= r_sq_v[gk];
                r_sq_rem[gk+1]  <= ge ? (rem_sh - trial) : rem_sh;
                r_sq_root[gk+1] <= {r_sq_root[gk][ROOT_BITS-2:0], ge};
                r_sq_rad[gk+1]  <= r_sq_rad[gk] << 2;
                r_sq_a[gk+1]    <= r_sq_a[gk];
                r_sq_tag[gk+1]  <= r_sq_tag[gk];
            end
        end
    end

    // Restoring divide stages
    for (genvar gq = 0; gq < QUOT_BITS; gq++) begin : g_div
        logic [ROOT_BITS:0] part, den_x;
        logic               ge;

        assign part  = {r_dv_rem[gq], r_dv_num[gq][QUOT_BITS-1]};
        assign den_x = {1'b0, r_dv_den[gq]};
        assign ge    = (part >= den_x);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[gq+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[gq+1]   <= r_dv_v[gq];
                r_dv_rem[gq+1] <= ROOT_BITS'(ge ? (part - den_x) : part);
                r_dv_num[gq+1] <= r_dv_num[gq] << 1;
                r_dv_den[gq+1] <= r_dv_den[gq];
                r_dv_q[gq+1]   <= {r_dv_q[gq][QUOT_BITS-2:0], ge};
                r_dv_tag[gq+1] <= r_dv_tag[gq];
            end
        end
    end

endmodule

FILE: rtl/core/pcns_checker.sv
// Port-level checker for the shading block, bound to the top level.
`include "point_cloud_normal_shading_macros.svh"

module pcns_checker
    import pcns_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_stall,
    input logic      o_stall,
    input logic      o_valid,
    input t_out_word o_word
);

    `PCNS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_word), "stalled word changed")
    `PCNS_ASSERT_NOW(a_shade_range, o_valid, (o_word.shade <= 16'sd16384) && (o_word.shade >= -16'sd16384), "shade out of range")
    `PCNS_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without output backpressure")
    `PCNS_ASSERT_NOW(a_reset_empty, $rose(i_rst_n), !o_valid, "word valid right after reset")

endmodule

bind point_cloud_normal_shading pcns_checker u_pcns_checker (.*);
